// File: sv/dtf_pkg.sv
package dtf_pkg;

  localparam int MAX_PRECISION_DEF = 18;
  localparam int DEFAULT_PRECISION = 6;
  localparam int PREC_W = 5;
  localparam int VAL_W = 64;
  localparam int MANT_W = 53;
  localparam int ACC_W = MANT_W + VAL_W;
  localparam int K_W = 7;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W = 4 * BCD_DIGITS;
  localparam int DIGIT_IDX_W = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] REG_PRECISION  = 2'd0;
  localparam logic [1:0] REG_FORCE_PLUS = 2'd1;
  localparam logic [1:0] REG_SPACE_SIGN = 2'd2;

  typedef struct packed {
    logic              has_sign;
    logic [7:0]        sign_char;
    logic [VAL_W-1:0]  ipart;
    logic [VAL_W-1:0]  frac;
    logic [PREC_W-1:0] prec;
    logic              sat;
  } job_t;

  // one double-dabble step: add-3 correction then shift in one bit
  function automatic logic [BCD_W-1:0] bcd_shift(input logic [BCD_W-1:0] bcd,
                                                 input logic in_bit);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (adj[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], in_bit};
  endfunction

endpackage

// File: sv/dtf_front.sv
module dtf_front #(
  parameter int MaxPrecision = dtf_pkg::MAX_PRECISION_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [dtf_pkg::VAL_W-1:0]   value_bits_i,
  input  logic [dtf_pkg::PREC_W-1:0]  precision_i,
  input  logic                        force_plus_i,
  input  logic                        space_sign_i,
  input  logic                        full_i,
  output logic                        push_o,
  output dtf_pkg::job_t               job_o
);

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_MUL   = 6'b000010,
    F_ADD   = 6'b000100,
    F_SHIFT = 6'b001000,
    F_FIX   = 6'b010000,
    F_PUSH  = 6'b100000
  } front_state_e;

  localparam int VW = dtf_pkg::VAL_W;
  localparam int AW = dtf_pkg::ACC_W;
  localparam int PW = dtf_pkg::PREC_W;

  front_state_e state_q, state_d;
  dtf_pkg::job_t job_q, job_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [AW:0] sum_q, sum_d;
  logic [VW:0] frac_q, frac_d;
  logic [VW-1:0] pw_q, pw_d;
  logic [dtf_pkg::K_W-1:0] k_q, k_d;
  logic frac_en_q, frac_en_d;
  logic [PW-1:0] cnt_q, cnt_d;

  // decode of the incoming double
  logic [10:0] ef;
  logic [dtf_pkg::MANT_W-1:0] mant;
  logic [10:0] kk;
  logic [VW-1:0] mask;
  logic [VW-1:0] ipart_dec;
  logic [dtf_pkg::MANT_W-1:0] f_dec;
  logic sat_dec, en_dec;
  logic [PW-1:0] p_eff;
  logic [AW:0] shifted;

  always_comb begin
    ef   = value_bits_i[62:52];
    mant = {ef != 11'd0, value_bits_i[51:0]};
    kk   = (ef == 11'd0) ? 11'd1074 : 11'd1075 - ef;
    mask = (VW'(1) << kk[5:0]) - VW'(1);
    sat_dec = (ef == 11'h7FF) || (ef > 11'd1086);
    en_dec  = (ef < 11'd1075) && (kk <= 11'd117);
    if (ef >= 11'd1075) begin
      ipart_dec = VW'(mant) << (ef - 11'd1075);
    end else if (kk < 11'd64) begin
      ipart_dec = VW'(mant) >> kk[5:0];
    end else begin
      ipart_dec = '0;
    end
    f_dec = (kk < 11'd64) ? (mant & mask[dtf_pkg::MANT_W-1:0]) : mant;
    if (precision_i == '0) begin
      p_eff = PW'(dtf_pkg::DEFAULT_PRECISION);
    end else if (precision_i > PW'(MaxPrecision)) begin
      p_eff = PW'(MaxPrecision);
    end else begin
      p_eff = precision_i;
    end
  end

  assign shifted = sum_q >> k_q;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    frac_d    = frac_q;
    pw_d      = pw_q;
    k_d       = k_q;
    frac_en_d = frac_en_q;
    cnt_d     = cnt_q;
    push_o    = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (start) begin
          job_d.has_sign  = value_bits_i[63] | force_plus_i | space_sign_i;
          job_d.sign_char = value_bits_i[63] ? dtf_pkg::CH_MINUS :
                            force_plus_i ? dtf_pkg::CH_PLUS : dtf_pkg::CH_SPACE;
          job_d.prec  = p_eff;
          job_d.sat   = sat_dec;
          job_d.ipart = sat_dec ? '1 : ipart_dec;
          job_d.frac  = '0;
          acc_d     = AW'(f_dec);
          k_d       = kk[dtf_pkg::K_W-1:0];
          frac_en_d = en_dec & ~sat_dec;
          pw_d      = VW'(1);
          cnt_d     = p_eff;
          state_d   = (en_dec & ~sat_dec) ? F_MUL : F_FIX;
        end
      end
      F_MUL: begin
        // times ten by shift and add
        acc_d = (acc_q << 3) + (acc_q << 1);
        pw_d  = (pw_q << 3) + (pw_q << 1);
        cnt_d = cnt_q - PW'(1);
        if (cnt_q == PW'(1)) begin
          state_d = F_ADD;
        end
      end
      F_ADD: begin
        // half of the last digit's weight, rounding half up
        sum_d   = {1'b0, acc_q} + ((AW+1)'(1) << (k_q - dtf_pkg::K_W'(1)));
        state_d = F_SHIFT;
      end
      F_SHIFT: begin
        frac_d  = shifted[VW:0];
        state_d = F_FIX;
      end
      F_FIX: begin
        if (frac_en_q) begin
          if (frac_q >= {1'b0, pw_q}) begin
            job_d.frac = '0;
            if (job_q.ipart == '1) begin
              job_d.sat = 1'b1;
            end else begin
              job_d.ipart = job_q.ipart + VW'(1);
            end
          end else begin
            job_d.frac = frac_q[VW-1:0];
          end
        end
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    acc_q     <= acc_d;
    sum_q     <= sum_d;
    frac_q    <= frac_d;
    pw_q      <= pw_d;
    k_q       <= k_d;
    frac_en_q <= frac_en_d;
    cnt_q     <= cnt_d;
  end

  assign busy  = (state_q != F_IDLE);
  assign job_o = job_q;

endmodule

// File: sv/dtf_queue.sv
module dtf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dtf_pkg::job_t data_i,
  input  logic          pop_i,
  output dtf_pkg::job_t data_o,
  output logic          avail_o,
  output logic          full_o
);

  localparam int Depth = dtf_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  dtf_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign avail_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));

endmodule

// File: sv/dtf_back.sv
module dtf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dtf_pkg::job_t job_i,
  input  logic          avail_i,
  output logic          pop_o,
  output logic          result_valid_o,
  output logic [7:0]    text_char_o,
  output logic          last_char_o,
  output logic          saturated_o
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_CONV = 6'b000010,
    B_SIGN = 6'b000100,
    B_INT  = 6'b001000,
    B_DOT  = 6'b010000,
    B_FRAC = 6'b100000
  } back_state_e;

  localparam int VW = dtf_pkg::VAL_W;
  localparam int BW = dtf_pkg::BCD_W;
  localparam int IW = dtf_pkg::DIGIT_IDX_W;
  localparam int CW = $clog2(VW);

  back_state_e state_q, state_d;
  dtf_pkg::job_t job_q, job_d;
  logic [VW-1:0] ish_q, ish_d, fsh_q, fsh_d;
  logic [BW-1:0] bcdi_q, bcdi_d, bcdf_q, bcdf_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic started_q, started_d;
  logic vld_q, vld_d;
  logic [7:0] chr_q, chr_d;
  logic last_q, last_d;
  logic [3:0] int_digit, frac_digit;

  assign int_digit  = bcdi_q[idx_q*4 +: 4];
  assign frac_digit = bcdf_q[idx_q*4 +: 4];

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    ish_d     = ish_q;
    fsh_d     = fsh_q;
    bcdi_d    = bcdi_q;
    bcdf_d    = bcdf_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    started_d = started_q;
    vld_d     = 1'b0;
    chr_d     = chr_q;
    last_d    = 1'b0;
    pop_o     = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (avail_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          ish_d   = job_i.ipart;
          fsh_d   = job_i.frac;
          bcdi_d  = '0;
          bcdf_d  = '0;
          cnt_d   = '0;
          state_d = B_CONV;
        end
      end
      B_CONV: begin
        // integer and fraction converted side by side
        bcdi_d = dtf_pkg::bcd_shift(bcdi_q, ish_q[VW-1]);
        bcdf_d = dtf_pkg::bcd_shift(bcdf_q, fsh_q[VW-1]);
        ish_d  = ish_q << 1;
        fsh_d  = fsh_q << 1;
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == CW'(VW - 1)) begin
          idx_d     = IW'(dtf_pkg::BCD_DIGITS - 1);
          started_d = 1'b0;
          state_d   = job_q.has_sign ? B_SIGN : B_INT;
        end
      end
      B_SIGN: begin
        vld_d   = 1'b1;
        chr_d   = job_q.sign_char;
        state_d = B_INT;
      end
      B_INT: begin
        if (int_digit == 4'd0 && idx_q != '0 && !started_q) begin
          idx_d = idx_q - IW'(1);
        end else begin
          vld_d     = 1'b1;
          chr_d     = dtf_pkg::CH_ZERO + {4'd0, int_digit};
          started_d = 1'b1;
          if (idx_q == '0) begin
            state_d = B_DOT;
          end else begin
            idx_d = idx_q - IW'(1);
          end
        end
      end
      B_DOT: begin
        vld_d   = 1'b1;
        chr_d   = dtf_pkg::CH_DOT;
        idx_d   = IW'(job_q.prec - dtf_pkg::PREC_W'(1));
        state_d = B_FRAC;
      end
      B_FRAC: begin
        vld_d = 1'b1;
        chr_d = dtf_pkg::CH_ZERO + {4'd0, frac_digit};
        if (idx_q == '0) begin
          last_d  = 1'b1;
          state_d = B_IDLE;
        end else begin
          idx_d = idx_q - IW'(1);
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    ish_q     <= ish_d;
    fsh_q     <= fsh_d;
    bcdi_q    <= bcdi_d;
    bcdf_q    <= bcdf_d;
    cnt_q     <= cnt_d;
    idx_q     <= idx_d;
    started_q <= started_d;
    chr_q     <= chr_d;
    last_q    <= last_d;
  end

  assign result_valid_o = vld_q;
  assign text_char_o    = chr_q;
  assign last_char_o    = last_q;
  assign saturated_o    = job_q.sat;

endmodule

// File: sv/double_to_fixed_decimal_text.sv
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------
// input     | start / busy           | value_bits_i
// config    | cfg_we_i               | cfg_index_i, cfg_data_i
// result    | result_valid_o strobe  | text_char_o, last_char_o, saturated_o
//
// the front takes a beat when busy is low; for p fraction digits it does one
// times-ten step per cycle on the exact product, then add, shift, fix, push
// the back converts integer and fraction by double dabble side by side, then
// emits one character per cycle, save while it skips leading zeros
// a two-entry queue lets the front decode the next beat during emission
// sustained rate is set by the back, which takes no new beat until it is done
// reset clears control and config; results cannot be stalled
module double_to_fixed_decimal_text #(
  parameter int MaxPrecision = dtf_pkg::MAX_PRECISION_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [dtf_pkg::VAL_W-1:0]   value_bits_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [dtf_pkg::PREC_W-1:0]  cfg_data_i,
  output logic                        result_valid_o,
  output logic [7:0]                  text_char_o,
  output logic                        last_char_o,
  output logic                        saturated_o
);

  // config registers
  logic [dtf_pkg::PREC_W-1:0] precision_q;
  logic force_plus_q, space_sign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision_q  <= '0;
      force_plus_q <= 1'b0;
      space_sign_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dtf_pkg::REG_PRECISION:  precision_q  <= cfg_data_i;
        dtf_pkg::REG_FORCE_PLUS: force_plus_q <= cfg_data_i[0];
        dtf_pkg::REG_SPACE_SIGN: space_sign_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  dtf_pkg::job_t front_job, queue_job;
  logic push, pop, avail, full;

  // front: decode and exact rounding of the fraction
  dtf_front #(.MaxPrecision(MaxPrecision)) u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .value_bits_i,
    .precision_i (precision_q),
    .force_plus_i(force_plus_q),
    .space_sign_i(space_sign_q),
    .full_i      (full),
    .push_o      (push),
    .job_o       (front_job)
  );

  // queue of decoded beats between front and back
  dtf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .data_i (front_job),
    .pop_i  (pop),
    .data_o (queue_job),
    .avail_o(avail),
    .full_o (full)
  );

  // back: digit conversion and character emission
  dtf_back u_back (
    .clk_i,
    .rst_ni,
    .job_i  (queue_job),
    .avail_i(avail),
    .pop_o  (pop),
    .result_valid_o,
    .text_char_o,
    .last_char_o,
    .saturated_o
  );

endmodule
